FILE: rtl/core/bdm_pkg.sv
`default_nettype none

package bdm_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int FW_BITS        = 11;
    localparam int FH_BITS        = 13;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam int MIN_WIDTH      = 6;
    localparam int MIN_HEIGHT     = 6;
    localparam int MAX_HEIGHT     = 4096;
    localparam int RESET_WIDTH    = 1024;
    localparam int RESET_HEIGHT   = 1024;
    localparam int ROW_BITS       = 13;
    localparam int OUT_ROW_BITS   = 12;
    localparam int SUM_BITS       = 14;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Bayer phase as {row parity, column parity}
    typedef enum logic [1:0] {
        PH_RED   = 2'b00,
        PH_GR    = 2'b01,
        PH_GB    = 2'b10,
        PH_BLUE  = 2'b11
    } t_phase;

    typedef struct packed {
        logic [7:0] sample;
        logic       drain;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_out_item;

    // [row][column][bit], row 0 oldest, column 4 newest
    typedef logic [4:0][4:0][7:0] t_window;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] green;
        logic signed [SUM_BITS-1:0] horiz;
        logic signed [SUM_BITS-1:0] vert;
        logic signed [SUM_BITS-1:0] diag;
    } t_sums;

    // Negative gives 0, otherwise divide by 16 and saturate at 255
    function automatic logic [7:0] sat_div16(input logic signed [SUM_BITS-1:0] s);
        logic [SUM_BITS-5:0] q;
        q = s[SUM_BITS-1:4];
        if (s[SUM_BITS-1]) begin
            return 8'd0;
        end
        if (q > (SUM_BITS-4)'(255)) begin
            return 8'hFF;
        end
        return q[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bdm_stream_if.sv
`default_nettype none

interface bdm_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bdm_kernel.sv
`default_nettype none

module bdm_kernel (
    input  bdm_pkg::t_window i_win,
    output bdm_pkg::t_sums   o_sums
);
    import bdm_pkg::*;

    function automatic logic signed [SUM_BITS-1:0] px(input logic [7:0] v);
        return $signed({{(SUM_BITS-8){1'b0}}, v});
    endfunction

    logic signed [SUM_BITS-1:0] pv;   // same column, two rows off
    logic signed [SUM_BITS-1:0] ph;   // same row, two columns off
    logic signed [SUM_BITS-1:0] dg;   // four diagonal neighbors
    logic signed [SUM_BITS-1:0] nh;   // left and right neighbors
    logic signed [SUM_BITS-1:0] nv;   // upper and lower neighbors
    logic signed [SUM_BITS-1:0] ctr;

    always_comb begin
        pv  = px(i_win[0][2]) + px(i_win[4][2]);
        ph  = px(i_win[2][0]) + px(i_win[2][4]);
        dg  = px(i_win[1][1]) + px(i_win[1][3]) + px(i_win[3][1]) + px(i_win[3][3]);
        nh  = px(i_win[2][1]) + px(i_win[2][3]);
        nv  = px(i_win[1][2]) + px(i_win[3][2]);
        ctr = px(i_win[2][2]);

        o_sums.green = (ctr <<< 3) + ((nh + nv) <<< 2) - ((pv + ph) <<< 1);
        o_sums.horiz = (ctr <<< 3) + (ctr <<< 1) + (nh <<< 3) - (ph <<< 1)
                       - (dg <<< 1) + pv;
        o_sums.vert  = (ctr <<< 3) + (ctr <<< 1) + (nv <<< 3) - (pv <<< 1)
                       - (dg <<< 1) + ph;
        o_sums.diag  = (ctr <<< 3) + (ctr <<< 2) + (dg <<< 2)
                       - ((pv + ph) <<< 1) - (pv + ph);
    end

endmodule

`default_nettype wire

FILE: rtl/core/bayer_demosaic_malvar.sv
// Bayer demosaic, 5x5 gradient-corrected interpolation (RGGB mosaic).
//
// i_pix (sink) takes one raw sample per item in raster order; drain items
// carry no sample and push out the last pixels of a frame once all samples
// are in (a drain before that is taken and dropped). o_pix (source) gives
// one RGB pixel per position; frame_end marks the last pixel of a frame.
// Pixel k comes out with input item k + 2*W + 2, so a frame needs
// 2*W + 2 drain items after its last sample.
// Throughput: one item per clock while o_pix keeps taking pixels. The line
// memory holds all four past rows of a column in one word, read when an item
// is accepted and written back as it leaves stage B, with forwarding between
// neighbors. An emitting item passes the registered memory read, kernel sums,
// and clamp and select before its pixel shows on o_pix. i_cfg_we writes
// frame_width (index 0) or frame_height (index 1) while the block is idle;
// the user must keep to this, the block does not enforce it. Values are
// clamped to 6..MAX_WIDTH and 6..4096. Reset is synchronous: counters clear,
// size goes to 1024 x 1024, the line memory is not cleared (border pixels
// never use unwritten data). When o_pix stalls, the output register holds its
// pixel and the pipeline keeps filling; i_pix.ready drops only when every stage is full.

`default_nettype none

module bayer_demosaic_malvar #(
    parameter int MAX_WIDTH = bdm_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bdm_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [bdm_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    bdm_stream_if.sink                           i_pix,
    bdm_stream_if.source                         o_pix
);
    import bdm_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_BITS = W_BITS + 1;
    localparam int W_RESET  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    // ---------------- configuration ----------------
    logic [W_BITS-1:0]  r_w;
    logic [FH_BITS-1:0] r_h;
    logic [31:0]        cfg_w;
    logic [31:0]        cfg_h;

    always_comb begin
        cfg_w = 32'(i_cfg_data[FW_BITS-1:0]);
        if (cfg_w < 32'(MIN_WIDTH)) cfg_w = 32'(MIN_WIDTH);
        if (cfg_w > 32'(MAX_WIDTH)) cfg_w = 32'(MAX_WIDTH);
        cfg_h = 32'(i_cfg_data[FH_BITS-1:0]);
        if (cfg_h < 32'(MIN_HEIGHT)) cfg_h = 32'(MIN_HEIGHT);
        if (cfg_h > 32'(MAX_HEIGHT)) cfg_h = 32'(MAX_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= W_BITS'(W_RESET);
            r_h <= FH_BITS'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_w <= W_BITS'(cfg_w);
                REG_FRAME_HEIGHT: r_h <= FH_BITS'(cfg_h);
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_b_valid, r_b_emit, r_c_valid, r_o_valid;
    logic o_free, c_adv, c_free, b_adv, b_free;

    always_comb begin
        o_free = !r_o_valid || o_pix.ready;
        c_adv  = r_c_valid && o_free;
        c_free = !r_c_valid || o_free;
        b_adv  = r_b_valid && (!r_b_emit || c_free);
        b_free = !r_b_valid || b_adv;
    end

    // take nothing while reset is held
    assign i_pix.ready = b_free && i_rst_n;

    // ---------------- stage A: counters, memory read ----------------
    t_in_item                  in_item;
    logic [ROW_BITS-1:0]       r_in_row,  n_in_row;
    logic [COL_BITS-1:0]       r_in_col,  n_in_col;
    logic [OUT_ROW_BITS-1:0]   r_out_row, n_out_row;
    logic [COL_BITS-1:0]       r_out_col, n_out_col;
    logic                      beyond, go, emit, last, border;
    logic                      in_col_wrap, out_col_wrap, out_row_end;
    logic [CMP_BITS-1:0]       in_col_inc, out_col_inc, out_col_p2;
    logic [ROW_BITS-1:0]       out_row_inc, out_row_p2;
    logic [7:0]                smp;

    assign in_item = i_pix.data;

    always_comb begin
        beyond       = r_in_row >= r_h;
        // a drain inside the frame is taken and dropped
        go           = i_pix.valid && b_free && (beyond || !in_item.drain);
        smp          = beyond ? 8'd0 : in_item.sample;
        emit         = (r_in_row > ROW_BITS'(2))
                       || (r_in_row == ROW_BITS'(2) && r_in_col >= COL_BITS'(2));
        in_col_inc   = CMP_BITS'(r_in_col) + CMP_BITS'(1);
        in_col_wrap  = in_col_inc >= CMP_BITS'(r_w);
        out_col_inc  = CMP_BITS'(r_out_col) + CMP_BITS'(1);
        out_col_p2   = CMP_BITS'(r_out_col) + CMP_BITS'(2);
        out_col_wrap = out_col_inc >= CMP_BITS'(r_w);
        out_row_inc  = ROW_BITS'(r_out_row) + ROW_BITS'(1);
        out_row_p2   = ROW_BITS'(r_out_row) + ROW_BITS'(2);
        out_row_end  = out_row_inc >= r_h;
        last         = out_row_end && out_col_wrap;
        border       = (r_out_row < OUT_ROW_BITS'(2)) || (r_out_col < COL_BITS'(2))
                       || (out_row_p2 >= r_h) || (out_col_p2 >= CMP_BITS'(r_w));

        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (go) begin
            if (in_col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_BITS'(1);
            end else begin
                n_in_col = in_col_inc[COL_BITS-1:0];
            end
            if (emit) begin
                if (last) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end else if (out_col_wrap) begin
                    n_out_col = '0;
                    n_out_row = out_row_inc[OUT_ROW_BITS-1:0];
                end else begin
                    n_out_col = out_col_inc[COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    // ---------------- stage B: line memory and window ----------------
    logic [7:0]          r_b_s;
    logic [1:0]          r_b_slot;
    logic [COL_BITS-1:0] r_b_addr;
    logic                r_b_border;
    logic [1:0]          r_b_phase;
    logic                r_b_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (go) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_b_emit   <= emit;
            r_b_s      <= smp;
            r_b_slot   <= r_in_row[1:0];
            r_b_addr   <= r_in_col;
            r_b_border <= border;
            r_b_phase  <= {r_out_row[0], r_out_col[0]};
            r_b_last   <= last;
        end
    end

    // one word per column: byte j holds the row whose index mod 4 is j
    logic [31:0] mem [MAX_WIDTH];
    logic [31:0] r_rd;
    logic [31:0] r_fwd_word;
    logic        r_fwd;
    logic [31:0] rd_word, wr_word;
    logic [4:0][7:0] col;
    t_window     r_win, n_win;
    t_sums       b_sums;

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rd <= mem[r_in_col];
        end
        if (b_adv) begin
            mem[r_b_addr] <= wr_word;
        end
    end

    // a write back in the same cycle as a read of that column is forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (go) begin
            r_fwd <= b_adv && (r_b_addr == r_in_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_fwd_word <= wr_word;
        end
    end

    always_comb begin
        rd_word = r_fwd ? r_fwd_word : r_rd;
        wr_word = rd_word;
        wr_word[{r_b_slot, 3'b000} +: 8] = r_b_s;
        for (int j = 0; j < 4; j++) begin
            col[j] = rd_word[{2'(r_b_slot + 2'(j)), 3'b000} +: 8];
        end
        col[4] = r_b_s;
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 4; x++) begin
                n_win[y][x] = r_win[y][x+1];
            end
            n_win[y][4] = col[y];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_win <= n_win;
        end
    end

    bdm_kernel u_kernel (
        .i_win  (n_win),
        .o_sums (b_sums)
    );

    // ---------------- stage C: clamp and select ----------------
    t_sums      r_c_sums;
    logic [7:0] r_c_raw;
    logic       r_c_border;
    logic [1:0] r_c_phase;
    logic       r_c_last;
    logic       c_load;
    t_out_item  c_item;
    t_out_item  r_o_item;
    logic [7:0] k_green, k_horiz, k_vert, k_diag;

    assign c_load = b_adv && r_b_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_load) begin
            r_c_valid <= 1'b1;
        end else if (c_adv) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_c_sums   <= b_sums;
            r_c_raw    <= n_win[2][2];
            r_c_border <= r_b_border;
            r_c_phase  <= r_b_phase;
            r_c_last   <= r_b_last;
        end
    end

    always_comb begin
        k_green = sat_div16(r_c_sums.green);
        k_horiz = sat_div16(r_c_sums.horiz);
        k_vert  = sat_div16(r_c_sums.vert);
        k_diag  = sat_div16(r_c_sums.diag);
        c_item.red       = 8'd0;
        c_item.green     = 8'd0;
        c_item.blue      = 8'd0;
        c_item.frame_end = r_c_last;
        unique case (t_phase'(r_c_phase))
            PH_RED: begin
                c_item.red = r_c_raw;
                if (!r_c_border) begin
                    c_item.green = k_green;
                    c_item.blue  = k_diag;
                end
            end
            PH_GR: begin
                c_item.green = r_c_raw;
                if (!r_c_border) begin
                    c_item.red  = k_horiz;
                    c_item.blue = k_vert;
                end
            end
            PH_GB: begin
                c_item.green = r_c_raw;
                if (!r_c_border) begin
                    c_item.red  = k_vert;
                    c_item.blue = k_horiz;
                end
            end
            PH_BLUE: begin
                c_item.blue = r_c_raw;
                if (!r_c_border) begin
                    c_item.red   = k_diag;
                    c_item.green = k_green;
                end
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_o_item <= c_item;
        end
    end

    assign o_pix.valid = r_o_valid;
    assign o_pix.data  = r_o_item;

endmodule

`default_nettype wire

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdm_pkg::*;

    localparam int LINE_W        = DEF_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 400;
    localparam int LIMIT         = 200000;

    typedef enum {FILL_UNIFORM, FILL_EXTREME} t_fill;
    typedef enum {KN_GREEN, KN_HORIZ, KN_VERT, KN_DIAG} t_kernel;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic src_valid = 1'b0;
    t_in_item src_item = '0;
    logic snk_ready = 1'b0;

    bdm_stream_if #(.t_payload(t_in_item)) pix_in ();
    bdm_stream_if #(.t_payload(t_out_item)) pix_out ();

    assign pix_in.valid  = src_valid;
    assign pix_in.data   = src_item;
    assign pix_out.ready = snk_ready;

    bayer_demosaic_malvar #(.MAX_WIDTH(LINE_W)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    always #6 clk = ~clk;

    // Demosaic state mirrored on the testbench side
    logic [FW_BITS-1:0] fw_reg = FW_BITS'(RESET_WIDTH);
    logic [FH_BITS-1:0] fh_reg = FH_BITS'(RESET_HEIGHT);
    bit [7:0] lmem [0:4*LINE_W-1];
    bit [7:0] win [0:4][0:4];
    int unsigned in_r = 0;
    int unsigned in_c = 0;
    int unsigned out_r = 0;
    int unsigned out_c = 0;

    t_in_item mosaic_feed [$];
    t_out_item pixels_due [$];

    int src_gap_pct = 13;
    int snk_gap_pct = 13;
    int stim_items = 0;
    int items_taken = 0;
    int pixels_seen = 0;
    int frames_seen = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int cycles = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Doubled 5x5 gradient-corrected kernels, divided by 16 and clamped
    function automatic logic [7:0] mhc_value(input t_kernel k);
        int cen, n1, s1, w1, e1, n2, s2, w2, e2, dg, acc;
        cen = win[2][2];
        n1 = win[1][2]; s1 = win[3][2]; w1 = win[2][1]; e1 = win[2][3];
        n2 = win[0][2]; s2 = win[4][2]; w2 = win[2][0]; e2 = win[2][4];
        dg = win[1][1] + win[1][3] + win[3][1] + win[3][3];
        acc = 0;
        case (k)
            KN_GREEN: acc = 8*cen + 4*(n1 + s1 + w1 + e1) - 2*(n2 + s2 + w2 + e2);
            KN_HORIZ: acc = 10*cen + 8*(w1 + e1) - 2*(w2 + e2) - 2*dg + n2 + s2;
            KN_VERT:  acc = 10*cen + 8*(n1 + s1) - 2*(n2 + s2) - 2*dg + w2 + e2;
            KN_DIAG:  acc = 12*cen + 4*dg - 3*(n2 + s2 + w2 + e2);
            default:  acc = 0;
        endcase
        if (acc < 0) return 8'd0;
        acc = acc / 16;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    task automatic demosaic_accept(input t_in_item it);
        int unsigned w, h, ic, r, c;
        logic [7:0] s, center;
        bit [7:0] fresh [0:4];
        logic beyond, emit, last, border;
        t_phase ph;
        t_out_item px;
        w = clamp_dim(fw_reg, MIN_WIDTH, LINE_W);
        h = clamp_dim(fh_reg, MIN_HEIGHT, MAX_HEIGHT);
        beyond = (in_r >= h);
        // drop a drain that comes before the frame's last sample
        if (!beyond && it.drain) return;
        s = beyond ? 8'd0 : it.sample;
        ic = (in_c >= LINE_W) ? LINE_W - 1 : in_c;
        for (int j = 0; j < 4; j++) fresh[j] = lmem[((in_r + j) % 4) * LINE_W + ic];
        fresh[4] = s;
        lmem[(in_r % 4) * LINE_W + ic] = s;
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
            win[y][4] = fresh[y];
        end
        emit = (in_r > 2) || (in_r == 2 && in_c >= 2);
        in_c++;
        if (in_c >= w) begin
            in_c = 0;
            in_r++;
        end
        if (!emit) return;

        r = out_r;
        c = out_c;
        border = (r < 2) || (c < 2) || (r + 2 >= h) || (c + 2 >= w);
        ph = t_phase'({r[0], c[0]});
        center = win[2][2];
        px = '0;
        case (ph)
            PH_RED: begin
                px.red = center;
                if (!border) begin
                    px.green = mhc_value(KN_GREEN);
                    px.blue  = mhc_value(KN_DIAG);
                end
            end
            PH_GR: begin
                px.green = center;
                if (!border) begin
                    px.red  = mhc_value(KN_HORIZ);
                    px.blue = mhc_value(KN_VERT);
                end
            end
            PH_GB: begin
                px.green = center;
                if (!border) begin
                    px.red  = mhc_value(KN_VERT);
                    px.blue = mhc_value(KN_HORIZ);
                end
            end
            default: begin
                px.blue = center;
                if (!border) begin
                    px.green = mhc_value(KN_GREEN);
                    px.red   = mhc_value(KN_DIAG);
                end
            end
        endcase

        last = (out_r + 1 >= h) && (out_c + 1 >= w);
        if (last) begin
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
        end else begin
            out_c++;
            if (out_c >= w) begin
                out_c = 0;
                out_r++;
            end
        end
        px.frame_end = last;
        pixels_due.push_back(px);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 50)
            $display("ERROR pixel %0d: %s is %0d, want %0d", pixels_seen, what, got, want);
        mismatches++;
    endtask

    // Source side
    always @(posedge clk) begin
        if (!rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && pix_in.ready) begin
                demosaic_accept(src_item);
                items_taken++;
            end
            if (!src_valid || pix_in.ready) begin
                if (mosaic_feed.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    src_valid <= 1'b1;
                    src_item  <= mosaic_feed.pop_front();
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            snk_ready <= 1'b0;
        end else begin
            if (pix_out.valid && snk_ready) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("pixel with none due, red", pix_out.data.red, 0);
                end else begin
                    want = pixels_due.pop_front();
                    if (pix_out.data.red !== want.red)
                        report_mismatch("red", pix_out.data.red, want.red);
                    if (pix_out.data.green !== want.green)
                        report_mismatch("green", pix_out.data.green, want.green);
                    if (pix_out.data.blue !== want.blue)
                        report_mismatch("blue", pix_out.data.blue, want.blue);
                    if (pix_out.data.frame_end !== want.frame_end)
                        report_mismatch("frame_end", pix_out.data.frame_end, want.frame_end);
                    if (want.frame_end) frames_seen++;
                end
                pixels_seen++;
            end
            snk_ready <= ($urandom_range(99) >= snk_gap_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d pixels still due", cycles,
                     pixels_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Hold until every item is in and every pixel is out, then let the pipe drain
    task automatic settle();
        do @(posedge clk);
        while (mosaic_feed.size() != 0 || src_valid || pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        if (idx == REG_FRAME_WIDTH) fw_reg = FW_BITS'(value);
        else fh_reg = FH_BITS'(value);
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_samples(input int n, input t_fill fill);
        t_in_item it;
        for (int k = 0; k < n; k++) begin
            // now and then a drain too early, which the block must drop
            if ($urandom_range(24) == 0) begin
                it.sample = 8'($urandom_range(255));
                it.drain  = 1'b1;
                mosaic_feed.push_back(it);
            end
            if (fill == FILL_EXTREME) it.sample = $urandom_range(1) ? 8'hFF : 8'h00;
            else it.sample = 8'($urandom_range(255));
            it.drain = 1'b0;
            mosaic_feed.push_back(it);
            stim_items++;
        end
    endtask

    // Flush items after the last sample; some carry a sample, which acts as a drain
    task automatic push_tail(input int n, input int spare);
        t_in_item it;
        for (int k = 0; k < n + spare; k++) begin
            it.sample = 8'($urandom_range(255));
            it.drain  = (k >= n) || ($urandom_range(3) != 0);
            mosaic_feed.push_back(it);
            if (k < n) stim_items++;
        end
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic feed_frame(input int w, input int h, input t_fill fill);
        int split;
        @(negedge clk);
        if ($urandom_range(3) == 0) begin
            split = $urandom_range(w*h - 1, 1);
            push_samples(split, fill);
            settle();
            @(negedge clk);
            push_samples(w*h - split, fill);
        end else begin
            push_samples(w*h, fill);
        end
        push_tail(2*w + 2, $urandom_range(2));
    endtask

    initial begin
        t_in_item it;
        int w, h, frame_no;
        t_fill fill;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest frame: early drain, then 0/255 checkerboards that drive the clamps
        set_size(MIN_WIDTH, MIN_HEIGHT);
        @(negedge clk);
        it.sample = 8'hA5;
        it.drain  = 1'b1;
        mosaic_feed.push_back(it);
        for (int k = 0; k < 24; k++) begin
            it.sample = ((((k / 6) ^ (k % 6)) & 1) != (k >= 12)) ? 8'hFF : 8'h00;
            it.drain  = 1'b0;
            mosaic_feed.push_back(it);
            stim_items++;
        end
        push_samples(12, FILL_UNIFORM);
        push_tail(14, 1);

        frame_no = 0;
        w = MIN_WIDTH;
        h = MIN_HEIGHT;
        while (stim_items < 25 + RANDOM_ITEMS || frame_no < 4) begin
            src_gap_pct = (frame_no == 2) ? 0 : 13;
            snk_gap_pct = (frame_no == 2) ? 0 : 13;
            if (frame_no == 1) begin
                // widest row, then narrow it mid-frame
                set_size(LINE_W, MIN_HEIGHT);
                @(negedge clk);
                push_samples(40, FILL_UNIFORM);
                settle();
                write_reg(REG_FRAME_WIDTH, MIN_WIDTH);
                @(negedge clk);
                push_samples(31, FILL_UNIFORM);
                push_tail(14, 2);
            end
            if (frame_no == 3) begin
                // tallest frame, cut short mid-frame
                set_size(MIN_WIDTH, MAX_HEIGHT);
                @(negedge clk);
                push_samples(48, FILL_EXTREME);
                settle();
                write_reg(REG_FRAME_HEIGHT, 8);
                @(negedge clk);
                push_tail(14, 2);
            end
            if (frame_no <= 3 || $urandom_range(1) == 1) begin
                w = $urandom_range(6, 3) * 2;
                h = $urandom_range(5, 3) * 2;
                if ($urandom_range(5) == 0) w++;
                if ($urandom_range(5) == 0) h++;
                set_size(w, h);
            end
            fill = ($urandom_range(3) == 0) ? FILL_EXTREME : FILL_UNIFORM;
            feed_frame(w, h, fill);
            frame_no++;
        end
        src_gap_pct = 13;
        snk_gap_pct = 13;

        settle();
        $display("Run covered %0d items taken, %0d pixels checked over %0d frames,",
                 items_taken, pixels_seen, frames_seen);
        $display("with %0d size register writes and %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
